[rtl/tmps_pkg.sv]
// Shared types and constants for the top-M positive score selector.
// No dependencies; compile first.
package tmps_pkg;

    localparam int MAX_LIST = 64;
    localparam int IDX_W    = $clog2(MAX_LIST);
    localparam int CNT_W    = IDX_W + 1;
    localparam int SCORE_W  = 32;
    localparam int ID_W     = 24;
    localparam int RANK_W   = 6;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [ID_W-1:0]           id;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // Strict (score, id) order: a before b.
    function automatic logic entry_less(input entry_t a, input entry_t b);
        logic r;
        if (a.score != b.score)
        begin
            r = (a.score < b.score);
        end
        else
        begin
            r = (a.id < b.id);
        end
        return r;
    endfunction

endpackage

[rtl/tmps_ifs.sv]
// Channel interfaces for the top-M positive score selector.
// Depends on tmps_pkg.
interface tmps_item_if import tmps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           doc_id;
    logic                      end_of_topic;
    modport source (output valid, score, doc_id, end_of_topic, input ready);
    modport sink (input valid, score, doc_id, end_of_topic, output ready);
endinterface

interface tmps_result_if import tmps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   out_doc_id;
    logic              slot_valid;
    logic [RANK_W-1:0] rank;
    logic              last_of_list;
    modport source (output valid, out_doc_id, slot_valid, rank, last_of_list, input ready);
    modport sink (input valid, out_doc_id, slot_valid, rank, last_of_list, output ready);
endinterface

interface tmps_cfg_if import tmps_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/top_m_positive_score_selector_unit.sv]
// Top-M positive score selector: keeps the best list_cap positive (score, id)
// pairs of a topic in one synchronous memory and emits them in descending order.
// Transactions are processed one at a time. A pair that is dropped, or inserted
// while the store is not full, is handled in ST_IDLE. Once the store is full, a
// pair scans the memory for its minimum through the single read port, whose
// read data is registered. On end_of_topic, each of the list_cap result slots
// costs one scan of the kept entries plus the output handshake.
// Depends on tmps_pkg and tmps_ifs.
module top_m_positive_score_selector_unit import tmps_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    tmps_item_if.sink   items,
    tmps_result_if.source results,
    tmps_cfg_if.sink    cfg
);

    // Entry store
    entry_t mem [MAX_LIST];
    entry_t rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;
    logic [IDX_W-1:0] mem_ra;

    // Control and working registers
    state_t state_reg, state_next;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             scan_max_reg, scan_max_next;
    logic             found_reg, found_next;
    entry_t           best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    entry_t           item_reg, item_next;
    logic             item_last_reg, item_last_next;
    logic [MAX_LIST-1:0] used_reg, used_next;
    logic [CNT_W-1:0] rank_reg, rank_next;
    logic [ID_W-1:0]  out_id_reg, out_id_next;
    logic             out_valid_slot_reg, out_valid_slot_next;

    logic [CNT_W-1:0] eff_cap;
    logic             in_pos;
    logic             skip;
    logic             take;
    entry_t           in_entry;

    // Clamp capacity to the range 1 to the store size
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(MAX_LIST))
        begin
            eff_cap = CNT_W'(MAX_LIST);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign in_entry.score = items.score;
    assign in_entry.id    = items.doc_id;
    assign in_pos         = (items.score != '0) && !items.score[SCORE_W-1];

    assign items.ready          = (state_reg == ST_IDLE);
    assign cfg.ready            = 1'b1;
    assign results.valid        = (state_reg == ST_EMIT);
    assign results.out_doc_id   = out_id_reg;
    assign results.slot_valid   = out_valid_slot_reg;
    assign results.rank         = rank_reg[RANK_W-1:0];
    assign results.last_of_list = (rank_reg == eff_cap - CNT_W'(1));
    assign mem_ra               = iss_reg[IDX_W-1:0];

    // Next state and datapath control
    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        iss_next            = iss_reg;
        pend_next           = pend_reg;
        cmp_idx_next        = cmp_idx_reg;
        scan_max_next       = scan_max_reg;
        found_next          = found_reg;
        best_next           = best_reg;
        best_idx_next       = best_idx_reg;
        item_next           = item_reg;
        item_last_next      = item_last_reg;
        used_next           = used_reg;
        rank_next           = rank_reg;
        out_id_next         = out_id_reg;
        out_valid_slot_next = out_valid_slot_reg;
        mem_we              = 1'b0;
        mem_wa              = count_reg[IDX_W-1:0];
        mem_wd              = in_entry;
        skip                = 1'b0;
        take                = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (items.valid)
                begin
                    item_next      = in_entry;
                    item_last_next = items.end_of_topic;
                    iss_next       = '0;
                    pend_next      = 1'b0;
                    found_next     = 1'b0;
                    rank_next      = '0;
                    if (in_pos && (count_reg < eff_cap))
                    begin
                        // Append while the store has room
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        scan_max_next = 1'b1;
                        state_next = items.end_of_topic ? ST_SCAN : ST_IDLE;
                    end
                    else if (in_pos && (count_reg != '0))
                    begin
                        // Full: look for the minimum
                        scan_max_next = 1'b0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        scan_max_next = 1'b1;
                        state_next    = items.end_of_topic ? ST_SCAN : ST_IDLE;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue reads
                if (iss_reg < count_reg)
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = iss_reg[IDX_W-1:0];
                    iss_next     = iss_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // Compare returned entry
                if (pend_reg)
                begin
                    skip = scan_max_reg && used_reg[cmp_idx_reg];
                    if (scan_max_reg)
                    begin
                        take = !skip && (!found_reg || entry_less(best_reg, rd_data_reg));
                    end
                    else
                    begin
                        take = !found_reg || entry_less(rd_data_reg, best_reg);
                    end
                    if (take)
                    begin
                        best_next     = rd_data_reg;
                        best_idx_next = cmp_idx_reg;
                        found_next    = 1'b1;
                    end
                end
                else if (iss_reg == count_reg)
                begin
                    iss_next   = '0;
                    found_next = 1'b0;
                    if (!scan_max_reg)
                    begin
                        // Replace the minimum on a strictly greater score
                        if (found_reg && (item_reg.score > best_reg.score))
                        begin
                            mem_we = 1'b1;
                            mem_wa = best_idx_reg;
                            mem_wd = item_reg;
                        end
                        scan_max_next = 1'b1;
                        rank_next     = '0;
                        state_next    = item_last_reg ? ST_SCAN : ST_IDLE;
                    end
                    else
                    begin
                        // Hold the best unused entry for output
                        out_id_next         = found_reg ? best_reg.id : '0;
                        out_valid_slot_next = found_reg;
                        if (found_reg)
                        begin
                            used_next[best_idx_reg] = 1'b1;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (results.ready)
                begin
                    if (rank_reg == eff_cap - CNT_W'(1))
                    begin
                        count_next = '0;
                        used_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rank_next  = rank_reg + CNT_W'(1);
                        iss_next   = '0;
                        pend_next  = 1'b0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cap_reg      <= CNT_W'(MAX_LIST);
            count_reg    <= '0;
            iss_reg      <= '0;
            pend_reg     <= 1'b0;
            scan_max_reg <= 1'b0;
            found_reg    <= 1'b0;
            used_reg     <= '0;
            rank_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            iss_reg      <= iss_next;
            pend_reg     <= pend_next;
            scan_max_reg <= scan_max_next;
            found_reg    <= found_next;
            used_reg     <= used_next;
            rank_reg     <= rank_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg        <= cmp_idx_next;
        best_reg           <= best_next;
        best_idx_reg       <= best_idx_next;
        item_reg           <= item_next;
        item_last_reg      <= item_last_next;
        out_id_reg         <= out_id_next;
        out_valid_slot_reg <= out_valid_slot_next;
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LIST))
        else $error("kept count exceeds store size");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(items.ready && results.valid))
        else $error("input accepted while a result is pending");

    a_clear_after_list: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.last_of_list) |=>
            (count_reg == '0) && (used_reg == '0))
        else $error("store not cleared after list end");

    a_scan_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (iss_reg <= count_reg))
        else $error("scan index past kept count");

endmodule
